### sv/imhd_pkg.sv
// ----------------------------------------------------------------------------
// imhd_pkg
// Shared constants and types of the indexed min-heap with decrease key.
// ----------------------------------------------------------------------------
package imhd_pkg;

	localparam int CAPACITY     = 1024;
	localparam int NUM_ELEMENTS = 1024;
	localparam int KEY_BITS     = 32;
	localparam int SLOT_W       = $clog2(CAPACITY);
	localparam int ELEM_W       = $clog2(NUM_ELEMENTS);
	localparam int CNT_W        = SLOT_W + 1;

	localparam logic [2:0] FN_INSERT   = 3'd0;
	localparam logic [2:0] FN_DECREASE = 3'd1;
	localparam logic [2:0] FN_EXTRACT  = 3'd2;
	localparam logic [2:0] FN_QUERY    = 3'd3;
	localparam logic [2:0] FN_CLEAR    = 3'd4;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_EMPTY       = 3'd1;
	localparam logic [2:0] ST_FULL        = 3'd2;
	localparam logic [2:0] ST_ABSENT      = 3'd3;
	localparam logic [2:0] ST_PRESENT     = 3'd4;
	localparam logic [2:0] ST_NOT_SMALLER = 3'd5;

	typedef struct packed {
		logic [ELEM_W-1:0]   elem;
		logic [KEY_BITS-1:0] key;
	} heap_ent_t;

endpackage

### sv/imhd_if.sv
// ----------------------------------------------------------------------------
// imhd_in_if / imhd_out_if
// Valid/ready channels that carry one request word and one response word.
// ----------------------------------------------------------------------------
interface imhd_in_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    func;
	logic [imhd_pkg::ELEM_W-1:0]   element;
	logic [imhd_pkg::KEY_BITS-1:0] key;

	modport source (output valid, func, element, key, input ready);
	modport sink (input valid, func, element, key, output ready);
endinterface

interface imhd_out_if;
	logic                          valid;
	logic                          ready;
	logic [imhd_pkg::ELEM_W-1:0]   out_element;
	logic [imhd_pkg::KEY_BITS-1:0] out_key;
	logic                          found;
	logic [imhd_pkg::CNT_W-1:0]    count;
	logic [2:0]                    status;

	modport source (output valid, out_element, out_key, found, count, status, input ready);
	modport sink (input valid, out_element, out_key, found, count, status, output ready);
endinterface

### sv/imhd_ram.sv
// ----------------------------------------------------------------------------
// imhd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module imhd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/indexed_min_heap_decrease_key.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key
// Indexed binary min-heap with insert, decrease key, extract, query and clear.
// ----------------------------------------------------------------------------
// Query and rejected requests pass through the lookup and check states before the
// response word; clear, unused codes and extracts that leave no sift skip the check state.
// Per level, a sift up reads then compares the parent, and a sift down reads the left
// child, reads the right child and compares, through the single read port of the heap
// memory. One request is in flight at a time; a new one is taken while the previous
// response waits. Reset empties the heap at once; no memory clearing pass.
module indexed_min_heap_decrease_key (
	input logic           clk,
	input logic           arst_n,
	imhd_in_if.sink       in_ch,
	imhd_out_if.source    out_ch
);

	localparam int SW = imhd_pkg::SLOT_W;
	localparam int CW = imhd_pkg::CNT_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LOOK   = 4'd1;
	localparam logic [3:0] S_CHK    = 4'd2;
	localparam logic [3:0] S_XLAST  = 4'd3;
	localparam logic [3:0] S_UP_RD  = 4'd4;
	localparam logic [3:0] S_UP_CMP = 4'd5;
	localparam logic [3:0] S_DN_L   = 4'd6;
	localparam logic [3:0] S_DN_R   = 4'd7;
	localparam logic [3:0] S_DN_C   = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0]                    state_q;
	logic [CW-1:0]                 cnt_q;
	logic [2:0]                    func_q;
	logic [imhd_pkg::ELEM_W-1:0]   elem_q;
	logic [imhd_pkg::KEY_BITS-1:0] key_q;
	logic [SW-1:0]                 slot_q;
	logic [SW-1:0]                 pos_q;
	imhd_pkg::heap_ent_t           item_q;
	imhd_pkg::heap_ent_t           left_q;
	logic [imhd_pkg::ELEM_W-1:0]   res_elem_q;
	logic [imhd_pkg::KEY_BITS-1:0] res_key_q;
	logic                          res_found_q;
	logic [2:0]                    res_status_q;
	logic                          out_valid_q;

	logic                          heap_we;
	logic [SW-1:0]                 heap_waddr;
	imhd_pkg::heap_ent_t           heap_wdata;
	logic [SW-1:0]                 heap_raddr;
	imhd_pkg::heap_ent_t           heap_rdata;
	logic                          es_we;
	logic [imhd_pkg::ELEM_W-1:0]   es_waddr;
	logic [SW-1:0]                 es_wdata;
	logic [imhd_pkg::ELEM_W-1:0]   es_raddr;
	logic [SW-1:0]                 es_rdata;

	logic                          accept;
	logic                          present;
	logic [SW-1:0]                 parent;
	logic [CW-1:0]                 lidx;
	logic [CW-1:0]                 ridx;
	logic                          pick_right;
	imhd_pkg::heap_ent_t           pick;
	logic [CW-1:0]                 cnt_dec;

	imhd_ram #(.WIDTH($bits(imhd_pkg::heap_ent_t)), .DEPTH(imhd_pkg::CAPACITY)) u_heap (
		.clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
		.raddr(heap_raddr), .rdata(heap_rdata)
	);

	imhd_ram #(.WIDTH(SW), .DEPTH(imhd_pkg::NUM_ELEMENTS)) u_slot (
		.clk(clk), .we(es_we), .waddr(es_waddr), .wdata(es_wdata),
		.raddr(es_raddr), .rdata(es_rdata)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	assign present    = ({1'b0, slot_q} < cnt_q) && (heap_rdata.elem == elem_q);
	assign parent     = (pos_q - SW'(1)) >> 1;
	assign lidx       = {pos_q, 1'b1};
	assign ridx       = lidx + CW'(1);
	assign pick_right = (ridx < cnt_q) && (heap_rdata.key < left_q.key);
	assign pick       = pick_right ? heap_rdata : left_q;
	assign cnt_dec    = cnt_q - CW'(1);

	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = pos_q;
		heap_wdata = item_q;
		heap_raddr = '0;
		es_we      = 1'b0;
		es_waddr   = item_q.elem;
		es_wdata   = pos_q;
		es_raddr   = in_ch.element;
		unique case (state_q)
			S_LOOK: begin
				heap_raddr = (func_q == imhd_pkg::FN_EXTRACT) ? cnt_dec[SW-1:0] : es_rdata;
			end
			S_UP_RD: begin
				heap_raddr = parent;
				if (pos_q == '0) begin
					heap_we = 1'b1;
					es_we   = 1'b1;
				end
			end
			S_UP_CMP: begin
				heap_we = 1'b1;
				es_we   = 1'b1;
				if (heap_rdata.key > item_q.key) begin
					heap_wdata = heap_rdata;
					es_waddr   = heap_rdata.elem;
				end
			end
			S_DN_L: begin
				heap_raddr = lidx[SW-1:0];
				if (lidx >= cnt_q) begin
					heap_we = 1'b1;
					es_we   = 1'b1;
				end
			end
			S_DN_R: begin
				heap_raddr = ridx[SW-1:0];
			end
			S_DN_C: begin
				heap_we = 1'b1;
				es_we   = 1'b1;
				if (item_q.key > pick.key) begin
					heap_wdata = pick;
					es_waddr   = pick.elem;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					priority if (func_q == imhd_pkg::FN_EXTRACT) begin
						if (cnt_q == '0) begin
							state_q <= S_DONE;
						end else begin
							cnt_q <= cnt_dec;
							state_q <= (cnt_dec == '0) ? S_DONE : S_XLAST;
						end
					end else if (func_q == imhd_pkg::FN_CLEAR) begin
						cnt_q   <= '0;
						state_q <= S_DONE;
					end else if (func_q > imhd_pkg::FN_CLEAR) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					priority if (func_q == imhd_pkg::FN_INSERT) begin
						if (present || cnt_q == CW'(imhd_pkg::CAPACITY)) begin
							state_q <= S_DONE;
						end else begin
							cnt_q   <= cnt_q + CW'(1);
							state_q <= S_UP_RD;
						end
					end else if (func_q == imhd_pkg::FN_DECREASE && present &&
					             key_q < heap_rdata.key) begin
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_XLAST: begin
					state_q <= S_DN_L;
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_DONE : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= (heap_rdata.key > item_q.key) ? S_UP_RD : S_DONE;
				end
				S_DN_L: begin
					state_q <= (lidx >= cnt_q) ? S_DONE : S_DN_R;
				end
				S_DN_R: begin
					state_q <= S_DN_C;
				end
				S_DN_C: begin
					state_q <= (item_q.key > pick.key) ? S_DN_L : S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q       <= in_ch.func;
			elem_q       <= in_ch.element;
			key_q        <= in_ch.key;
			res_elem_q   <= in_ch.element;
			res_key_q    <= '0;
			res_found_q  <= 1'b0;
			res_status_q <= imhd_pkg::ST_OK;
		end
		unique case (state_q)
			S_LOOK: begin
				slot_q <= es_rdata;
				if (func_q == imhd_pkg::FN_EXTRACT) begin
					if (cnt_q == '0) begin
						res_status_q <= imhd_pkg::ST_EMPTY;
					end else begin
						res_elem_q <= heap_rdata.elem;
						res_key_q  <= heap_rdata.key;
					end
				end
			end
			S_CHK: begin
				item_q.elem <= elem_q;
				item_q.key  <= key_q;
				unique case (func_q)
					imhd_pkg::FN_INSERT: begin
						pos_q <= cnt_q[SW-1:0];
						if (present) begin
							res_status_q <= imhd_pkg::ST_PRESENT;
						end else if (cnt_q == CW'(imhd_pkg::CAPACITY)) begin
							res_status_q <= imhd_pkg::ST_FULL;
						end
					end
					imhd_pkg::FN_DECREASE: begin
						pos_q <= slot_q;
						if (present) begin
							if (key_q >= heap_rdata.key) begin
								res_status_q <= imhd_pkg::ST_NOT_SMALLER;
							end
						end else begin
							res_status_q <= imhd_pkg::ST_ABSENT;
						end
					end
					imhd_pkg::FN_QUERY: begin
						if (present) begin
							res_found_q <= 1'b1;
							res_key_q   <= heap_rdata.key;
						end else begin
							res_status_q <= imhd_pkg::ST_ABSENT;
						end
					end
					default: begin
					end
				endcase
			end
			S_XLAST: begin
				item_q <= heap_rdata;
				pos_q  <= '0;
			end
			S_UP_CMP: begin
				if (heap_rdata.key > item_q.key) begin
					pos_q <= parent;
				end
			end
			S_DN_R: begin
				left_q <= heap_rdata;
			end
			S_DN_C: begin
				if (item_q.key > pick.key) begin
					pos_q <= pick_right ? ridx[SW-1:0] : lidx[SW-1:0];
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
			out_ch.out_element <= res_elem_q;
			out_ch.out_key     <= res_key_q;
			out_ch.found       <= res_found_q;
			out_ch.count       <= cnt_q;
			out_ch.status      <= res_status_q;
		end
	end

	assign out_ch.valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(imhd_pkg::CAPACITY))
		else $error("heap count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n) accept |=> state_q == S_LOOK)
		else $error("accepted request did not start lookup");

	assert property (@(posedge clk) disable iff (!arst_n)
		heap_we |-> (state_q == S_UP_RD || state_q == S_UP_CMP ||
		             state_q == S_DN_L || state_q == S_DN_C))
		else $error("heap write outside a sift");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DN_C) |-> (lidx < cnt_q))
		else $error("sift down compared past the last entry");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the indexed min-heap against a behavioral heap kept in the bench:
// a table of directed requests, then random operation mixes with random
// stalls on both channels, each response word compared field by field.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic [imhd_pkg::ELEM_W-1:0]   elem;
		logic [imhd_pkg::KEY_BITS-1:0] key;
		logic                          found;
		logic [imhd_pkg::CNT_W-1:0]    count;
		logic [2:0]                    status;
	} resp_t;

	typedef struct {
		logic [2:0]                    func;
		logic [imhd_pkg::ELEM_W-1:0]   elem;
		logic [imhd_pkg::KEY_BITS-1:0] key;
		bit                            fixed;
		resp_t                         resp;
	} row_t;

	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	imhd_in_if  in_ch ();
	imhd_out_if out_ch ();

	indexed_min_heap_decrease_key i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	logic [imhd_pkg::ELEM_W-1:0]   hp_elem [imhd_pkg::CAPACITY];
	logic [imhd_pkg::KEY_BITS-1:0] hp_key [imhd_pkg::CAPACITY];
	int                            elem_pos [imhd_pkg::NUM_ELEMENTS];
	bit                            elem_in [imhd_pkg::NUM_ELEMENTS];
	int                            hp_count;

	resp_t pending_resp[$];
	int    errors;
	int    idle_cycles;
	bit    stim_done;
	row_t  plan[$];

	function automatic void swap_pos(int a, int b);
		logic [imhd_pkg::ELEM_W-1:0]   e;
		logic [imhd_pkg::KEY_BITS-1:0] k;
		e = hp_elem[a];
		k = hp_key[a];
		hp_elem[a] = hp_elem[b];
		hp_key[a] = hp_key[b];
		hp_elem[b] = e;
		hp_key[b] = k;
		elem_pos[hp_elem[a]] = a;
		elem_pos[hp_elem[b]] = b;
	endfunction

	function automatic void bubble_up(int p);
		int q;
		while (p > 0) begin
			q = (p - 1) / 2;
			if (!(hp_key[q] > hp_key[p]))
				break;
			swap_pos(q, p);
			p = q;
		end
	endfunction

	function automatic void bubble_down(int p);
		int l;
		int r;
		int c;
		forever begin
			l = 2 * p + 1;
			r = 2 * p + 2;
			if (r < hp_count)
				c = (hp_key[r] < hp_key[l]) ? r : l;
			else if (l < hp_count)
				c = l;
			else
				break;
			if (!(hp_key[p] > hp_key[c]))
				break;
			swap_pos(c, p);
			p = c;
		end
	endfunction

	function automatic resp_t heap_apply(logic [2:0] func, logic [imhd_pkg::ELEM_W-1:0] elem,
			logic [imhd_pkg::KEY_BITS-1:0] key);
		resp_t r;
		int    p;
		r.elem = elem;
		r.key = '0;
		r.found = 1'b0;
		r.status = imhd_pkg::ST_OK;
		case (func)
			imhd_pkg::FN_INSERT: begin
				if (elem_in[elem])
					r.status = imhd_pkg::ST_PRESENT;
				else if (hp_count >= imhd_pkg::CAPACITY)
					r.status = imhd_pkg::ST_FULL;
				else begin
					p = hp_count;
					hp_elem[p] = elem;
					hp_key[p] = key;
					elem_pos[elem] = p;
					elem_in[elem] = 1'b1;
					hp_count++;
					bubble_up(p);
				end
			end
			imhd_pkg::FN_DECREASE: begin
				if (!elem_in[elem])
					r.status = imhd_pkg::ST_ABSENT;
				else begin
					p = elem_pos[elem];
					if (key >= hp_key[p])
						r.status = imhd_pkg::ST_NOT_SMALLER;
					else begin
						hp_key[p] = key;
						bubble_up(p);
					end
				end
			end
			imhd_pkg::FN_EXTRACT: begin
				if (hp_count == 0)
					r.status = imhd_pkg::ST_EMPTY;
				else begin
					r.elem = hp_elem[0];
					r.key = hp_key[0];
					elem_in[hp_elem[0]] = 1'b0;
					hp_count--;
					if (hp_count > 0) begin
						hp_elem[0] = hp_elem[hp_count];
						hp_key[0] = hp_key[hp_count];
						elem_pos[hp_elem[0]] = 0;
						bubble_down(0);
					end
				end
			end
			imhd_pkg::FN_QUERY: begin
				if (elem_in[elem]) begin
					r.found = 1'b1;
					r.key = hp_key[elem_pos[elem]];
				end else
					r.status = imhd_pkg::ST_ABSENT;
			end
			imhd_pkg::FN_CLEAR: begin
				foreach (elem_in[i])
					elem_in[i] = 1'b0;
				hp_count = 0;
			end
			default: ;
		endcase
		r.count = hp_count[imhd_pkg::CNT_W-1:0];
		return r;
	endfunction

	function automatic void add_row(logic [2:0] f, int e, logic [imhd_pkg::KEY_BITS-1:0] k);
		row_t w;
		w.func = f;
		w.elem = e[imhd_pkg::ELEM_W-1:0];
		w.key = k;
		w.fixed = 1'b0;
		plan = {plan, w};
	endfunction

	function automatic void add_fixed(logic [2:0] f, int e, logic [imhd_pkg::KEY_BITS-1:0] k,
			int re, logic [imhd_pkg::KEY_BITS-1:0] rk, bit fd, int cnt, logic [2:0] st);
		row_t w;
		w.func = f;
		w.elem = e[imhd_pkg::ELEM_W-1:0];
		w.key = k;
		w.fixed = 1'b1;
		w.resp.elem = re[imhd_pkg::ELEM_W-1:0];
		w.resp.key = rk;
		w.resp.found = fd;
		w.resp.count = cnt[imhd_pkg::CNT_W-1:0];
		w.resp.status = st;
		plan = {plan, w};
	endfunction

	function automatic int short_or_long_gap();
		if ($urandom_range(0, 3) == 0)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_word(row_t w);
		resp_t r;
		int    g;
		g = short_or_long_gap();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		r = heap_apply(w.func, w.elem, w.key);
		if (w.fixed && r != w.resp) begin
			$error("table row disagrees with heap model: func %0d", w.func);
			errors++;
		end
		pending_resp = {pending_resp, r};
		in_ch.valid <= 1'b1;
		in_ch.func <= w.func;
		in_ch.element <= w.elem;
		in_ch.key <= w.key;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	function automatic row_t random_word();
		row_t w;
		int   sel;
		int   e;
		w.fixed = 1'b0;
		sel = $urandom_range(0, 99);
		e = (hp_count > 0 && $urandom_range(0, 1)) ?
			int'(hp_elem[$urandom_range(0, hp_count - 1)]) : $urandom_range(0, 1023);
		w.elem = e[imhd_pkg::ELEM_W-1:0];
		w.key = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 200);
		if (sel < 45)
			w.func = imhd_pkg::FN_INSERT;
		else if (sel < 63) begin
			w.func = imhd_pkg::FN_DECREASE;
			if (elem_in[e] && $urandom_range(0, 3) != 0)
				w.key = $urandom_range(0, 1) ? hp_key[elem_pos[e]] - 1 : $urandom_range(0, 50);
		end else if (sel < 83)
			w.func = imhd_pkg::FN_EXTRACT;
		else if (sel < 96)
			w.func = imhd_pkg::FN_QUERY;
		else if (sel < 98)
			w.func = imhd_pkg::FN_CLEAR;
		else
			w.func = 3'($urandom_range(5, 7));
		return w;
	endfunction

	initial begin
		row_t w;
		int   e;
		errors = 0;
		stim_done = 1'b0;
		hp_count = 0;
		foreach (elem_in[i])
			elem_in[i] = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.func = imhd_pkg::FN_CLEAR;
		in_ch.element = '0;
		in_ch.key = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_fixed(imhd_pkg::FN_EXTRACT, 5, 0, 5, 0, 0, 0, imhd_pkg::ST_EMPTY);
		add_fixed(imhd_pkg::FN_QUERY, 1023, 0, 1023, 0, 0, 0, imhd_pkg::ST_ABSENT);
		add_fixed(imhd_pkg::FN_DECREASE, 0, 0, 0, 0, 0, 0, imhd_pkg::ST_ABSENT);
		add_fixed(imhd_pkg::FN_INSERT, 1023, 32'hFFFF_FFFF, 1023, 0, 0, 1, imhd_pkg::ST_OK);
		add_fixed(imhd_pkg::FN_INSERT, 1023, 7, 1023, 0, 0, 1, imhd_pkg::ST_PRESENT);
		add_fixed(imhd_pkg::FN_DECREASE, 1023, 32'hFFFF_FFFF, 1023, 0, 0, 1,
			imhd_pkg::ST_NOT_SMALLER);
		add_fixed(imhd_pkg::FN_INSERT, 0, 0, 0, 0, 0, 2, imhd_pkg::ST_OK);
		add_row(imhd_pkg::FN_INSERT, 512, 32'h8000_0000);
		add_row(imhd_pkg::FN_INSERT, 341, 32'h5555_5555);
		add_row(imhd_pkg::FN_INSERT, 682, 32'h5555_5555);
		add_row(imhd_pkg::FN_DECREASE, 1023, 32'hAAAA_AAAA);
		add_row(imhd_pkg::FN_DECREASE, 682, 32'h0);
		add_fixed(imhd_pkg::FN_QUERY, 0, 0, 0, 0, 1, 5, imhd_pkg::ST_OK);
		add_row(imhd_pkg::FN_QUERY, 1023, 0);
		add_row(imhd_pkg::FN_EXTRACT, 0, 0);
		add_row(imhd_pkg::FN_EXTRACT, 0, 0);
		add_row(imhd_pkg::FN_INSERT, 7, 32'h0);
		add_row(imhd_pkg::FN_EXTRACT, 0, 0);
		add_fixed(3'd5, 9, 9, 9, 0, 0, 3, imhd_pkg::ST_OK);
		add_fixed(3'd7, 1023, 32'hFFFF_FFFF, 1023, 0, 0, 3, imhd_pkg::ST_OK);
		add_fixed(imhd_pkg::FN_CLEAR, 0, 0, 0, 0, 0, 0, imhd_pkg::ST_OK);
		add_row(imhd_pkg::FN_INSERT, 3, 3);
		add_fixed(imhd_pkg::FN_EXTRACT, 0, 0, 3, 3, 0, 0, imhd_pkg::ST_OK);
		add_fixed(imhd_pkg::FN_QUERY, 3, 0, 3, 0, 0, 0, imhd_pkg::ST_ABSENT);
		foreach (plan[i])
			send_word(plan[i]);

		// Insert-heavy mix so the heap grows deep, with one full drain pause.
		for (int i = 0; i < 870; i++) begin
			if (i == 435) begin
				in_ch.valid <= 1'b0;
				wait (pending_resp.size() == 0);
			end
			if (i < 10 || i % 3 == 0) begin
				w = random_word();
			end else begin
				w.fixed = 1'b0;
				w.func = imhd_pkg::FN_INSERT;
				e = $urandom_range(0, 1023);
				w.elem = e[imhd_pkg::ELEM_W-1:0];
				w.key = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 100);
			end
			send_word(w);
		end
		w.fixed = 1'b0;
		w.func = imhd_pkg::FN_CLEAR;
		send_word(w);
		w.func = imhd_pkg::FN_INSERT;
		w.elem = 1;
		w.key = 1;
		send_word(w);
		in_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		int g;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			g = short_or_long_gap();
			if (g > 0) begin
				out_ch.ready <= 1'b0;
				repeat (g - 1) @(posedge clk);
			end else
				out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		resp_t want;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_ch.valid && out_ch.ready) begin
				if (pending_resp.size() == 0) begin
					$error("response word with none expected");
					errors++;
				end else begin
					want = pending_resp.pop_front();
					if (out_ch.out_element !== want.elem) begin
						$error("out_element: expected %0d, got %0d", want.elem, out_ch.out_element);
						errors++;
					end
					if (out_ch.out_key !== want.key) begin
						$error("out_key: expected %0d, got %0d", want.key, out_ch.out_key);
						errors++;
					end
					if (out_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, out_ch.found);
						errors++;
					end
					if (out_ch.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, out_ch.count);
						errors++;
					end
					if (out_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_ch.status);
						errors++;
					end
				end
			end
		end else
			idle_cycles <= 0;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
			if (stim_done && pending_resp.size() == 0) begin
				repeat (60) @(posedge clk);
				if (errors == 0 && pending_resp.size() == 0)
					$display("testbench: done, clean");
				else
					$display("testbench: done, errors");
				$finish;
			end
		end
	end
endmodule
